### src/utms_pkg.sv
// Shared types and constants for the unimodal table mode search block.
`timescale 1ns / 1ps
`default_nettype none
package utms_pkg;
	localparam int XW = 34;
	localparam logic [15:0] SPLIT_FRAC = 16'd25032;
	localparam logic signed [XW-1:0] I32_MAX = 34'sd2147483647;
	localparam logic signed [XW-1:0] I32_MIN = -34'sd2147483648;

	typedef logic [1:0] status_t;
	localparam status_t ST_FOUND = 2'd0;
	localparam status_t ST_NONE = 2'd1;
	localparam status_t ST_NOT_UNIMODAL = 2'd2;

	typedef logic [4:0] cmd_t;
	localparam cmd_t CMD_NOP = 5'd0;
	localparam cmd_t CMD_INIT = 5'd1;
	localparam cmd_t CMD_RD0 = 5'd2;
	localparam cmd_t CMD_RD1 = 5'd3;
	localparam cmd_t CMD_RD2 = 5'd4;
	localparam cmd_t CMD_RDN = 5'd5;
	localparam cmd_t CMD_WB0 = 5'd6;
	localparam cmd_t CMD_WB1 = 5'd7;
	localparam cmd_t CMD_WB2 = 5'd8;
	localparam cmd_t CMD_WBN = 5'd9;
	localparam cmd_t CMD_MID = 5'd10;
	localparam cmd_t CMD_PSL = 5'd11;
	localparam cmd_t CMD_PSZ = 5'd12;
	localparam cmd_t CMD_PSR = 5'd13;
	localparam cmd_t CMD_PSTEP = 5'd14;
	localparam cmd_t CMD_PHIT = 5'd15;
	localparam cmd_t CMD_MUL = 5'd16;
	localparam cmd_t CMD_SPLIT = 5'd17;
	localparam cmd_t CMD_UPD = 5'd18;
	localparam cmd_t CMD_WSTART = 5'd19;
	localparam cmd_t CMD_WSTEP = 5'd20;
	localparam cmd_t CMD_FIN_TWO = 5'd21;
	localparam cmd_t CMD_FIN_ADJ = 5'd22;
	localparam cmd_t CMD_FIN_MID = 5'd23;
	localparam cmd_t CMD_FIN_NONE = 5'd24;
	localparam cmd_t CMD_FIN_NU = 5'd25;
	localparam cmd_t CMD_EMIT = 5'd26;

	typedef struct packed {
		logic two_pt;
		logic f1_zero;
		logic f1_below;
		logic adjacent;
		logic fn_below;
		logic fn_ne_f1;
		logic th_gt;
		logic ot_gt;
		logic left_zero;
		logic right_max;
		logic step_done;
		logic probe_out;
		logic fn_pos;
		logic fn_lt_f1;
		logic walk_in;
		logic out_free;
	} flags_t;
endpackage
`default_nettype wire

### src/utms_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module utms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### src/utms_dp.sv
// Datapath: table storage, search points, values, step counter and result register.
`timescale 1ns / 1ps
`default_nettype none
module utms_dp #(
	parameter int TABLE_DEPTH = 1024,
	parameter int MAX_TRIALS = 100
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire utms_pkg::cmd_t cmd,
	input wire logic load_en,
	input wire logic [31:0] load_data,
	input wire logic [31:0] domain_left,
	output utms_pkg::flags_t flags,
	output logic m_valid,
	input wire logic m_ready,
	output logic [31:0] mode_index,
	output utms_pkg::status_t status
);
	import utms_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = $clog2(MAX_TRIALS + 1);

	logic [CW-1:0] count_q;
	logic signed [XW-1:0] left_q, right_q, x0_q, x1_q, x2_q, xn_q, res_mode_q;
	logic [31:0] f0_q, f1_q, f2_q, fn_q, rdata;
	logic [SW-1:0] step_q;
	logic dir_q, th_q, rv_q;
	logic [48:0] prod_q;
	status_t res_st_q;
	logic out_valid_q;
	logic [31:0] out_mode_q;
	status_t out_st_q;

	logic signed [XW-1:0] rk, roff, sum, mid0, mid1, h0, h2, xa, xb, xc, xd, pnext;
	logic [31:0] fv;
	logic ram_we;
	logic [AW-1:0] raddr;

	assign ram_we = load_en && (count_q < CW'(TABLE_DEPTH));

	always_comb begin
		case (cmd)
			CMD_RD0: rk = x0_q;
			CMD_RD1: rk = x1_q;
			CMD_RD2: rk = x2_q;
			default: rk = xn_q;
		endcase
	end
	assign roff = rk - left_q;
	assign raddr = roff[AW-1:0];

	utms_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(load_data),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign fv = rv_q ? rdata : 32'd0;
	assign sum = XW'($signed(domain_left)) + XW'(count_q) - XW'(1);
	assign h0 = $signed(x0_q + XW'(x0_q[XW-1])) >>> 1;
	assign h2 = $signed(x2_q + XW'(x2_q[XW-1])) >>> 1;
	assign mid0 = h0 + h2;
	always_comb begin
		mid1 = mid0;
		if (mid1 <= x0_q) mid1 = mid1 + XW'(1);
		if (mid1 >= x2_q) mid1 = mid1 - XW'(1);
	end
	assign xa = x0_q + $signed({1'b0, prod_q[48:16]});
	always_comb begin
		xb = (xa == x0_q) ? xa + XW'(1) : xa;
		xc = (xb == x2_q) ? xb - XW'(1) : xb;
		if (xc == x1_q) xd = (x1_q - XW'(1) == x0_q) ? xc + XW'(1) : xc - XW'(1);
		else xd = xc;
	end
	assign pnext = dir_q ? xn_q - XW'(step_q) : xn_q + XW'(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we) count_q <= count_q + CW'(1);
			if (cmd == CMD_EMIT) begin
				count_q <= '0;
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rv_q <= (rk >= left_q) && (rk <= right_q);
		case (cmd)
			CMD_INIT: begin
				left_q <= XW'($signed(domain_left));
				x0_q <= XW'($signed(domain_left));
				right_q <= (sum > I32_MAX) ? I32_MAX : sum;
				x2_q <= (sum > I32_MAX) ? I32_MAX : sum;
			end
			CMD_WB0: f0_q <= fv;
			CMD_WB1: f1_q <= fv;
			CMD_WB2: f2_q <= fv;
			CMD_WBN: fn_q <= fv;
			CMD_MID: x1_q <= mid1;
			CMD_PSL: begin
				xn_q <= (left_q != I32_MIN) ? left_q : '0;
				dir_q <= 1'b0;
				step_q <= SW'(1);
			end
			CMD_PSZ: begin
				xn_q <= '0;
				dir_q <= 1'b0;
				step_q <= SW'(1);
			end
			CMD_PSR: begin
				xn_q <= right_q;
				dir_q <= 1'b1;
				step_q <= SW'(1);
			end
			CMD_PSTEP: begin
				xn_q <= pnext;
				step_q <= step_q + SW'(1);
			end
			CMD_PHIT: begin
				x1_q <= xn_q;
				f1_q <= fn_q;
			end
			CMD_MUL: prod_q <= SPLIT_FRAC * 33'(x2_q - x0_q);
			CMD_SPLIT: begin
				xn_q <= xd;
				th_q <= (xd >= x1_q);
			end
			CMD_UPD: begin
				if ((fn_q != f1_q) ? (fn_q < f1_q) : !(th_q ? f2_q > f1_q : f0_q > f1_q)) begin
					if (th_q) begin
						x2_q <= xn_q;
						f2_q <= fn_q;
					end else begin
						x0_q <= xn_q;
						f0_q <= fn_q;
					end
				end else begin
					if (th_q) begin
						x0_q <= x1_q;
						f0_q <= f1_q;
					end else begin
						x2_q <= x1_q;
						f2_q <= f1_q;
					end
					x1_q <= xn_q;
					f1_q <= fn_q;
				end
			end
			CMD_WSTART: step_q <= SW'(1);
			CMD_WSTEP: begin
				xn_q <= th_q ? xn_q + XW'(1) : xn_q - XW'(1);
				step_q <= step_q + SW'(1);
			end
			CMD_FIN_TWO: begin
				res_mode_q <= (f0_q <= f2_q) ? x2_q : x0_q;
				res_st_q <= ST_FOUND;
			end
			CMD_FIN_ADJ: begin
				if (f0_q > f2_q) res_mode_q <= (f1_q > f0_q) ? x1_q : x0_q;
				else res_mode_q <= (f1_q > f2_q) ? x1_q : x2_q;
				res_st_q <= ST_FOUND;
			end
			CMD_FIN_MID: begin
				res_mode_q <= x1_q;
				res_st_q <= ST_FOUND;
			end
			CMD_FIN_NONE: begin
				res_mode_q <= '0;
				res_st_q <= ST_NONE;
			end
			CMD_FIN_NU: begin
				res_mode_q <= '0;
				res_st_q <= ST_NOT_UNIMODAL;
			end
			CMD_EMIT: begin
				out_mode_q <= res_mode_q[31:0];
				out_st_q <= res_st_q;
			end
			default: ;
		endcase
	end

	assign flags.two_pt = x2_q <= x0_q + XW'(1);
	assign flags.f1_zero = (f1_q == 32'd0);
	assign flags.f1_below = (f1_q < f0_q) && (f1_q < f2_q);
	assign flags.adjacent = (x0_q + XW'(1) >= x1_q) && (x1_q >= x2_q - XW'(1));
	assign flags.fn_below = (fn_q < f0_q) && (fn_q < f2_q);
	assign flags.fn_ne_f1 = (fn_q != f1_q);
	assign flags.th_gt = th_q ? (f2_q > f1_q) : (f0_q > f1_q);
	assign flags.ot_gt = th_q ? (f0_q > f1_q) : (f2_q > f1_q);
	assign flags.left_zero = (left_q == '0);
	assign flags.right_max = (right_q == I32_MAX);
	assign flags.step_done = (step_q >= SW'(MAX_TRIALS));
	assign flags.probe_out = dir_q ? (xn_q <= left_q) : (xn_q >= right_q);
	assign flags.fn_pos = (fn_q != 32'd0);
	assign flags.fn_lt_f1 = (fn_q < f1_q);
	assign flags.walk_in = (xn_q >= x0_q) && (xn_q <= x2_q);
	assign flags.out_free = !out_valid_q || m_ready;

	assign m_valid = out_valid_q;
	assign mode_index = out_mode_q;
	assign status = out_st_q;
endmodule
`default_nettype wire

### src/utms_ctrl.sv
// Controller: sequences loading, probes, golden-section loop, tie walk and result transfer.
`timescale 1ns / 1ps
`default_nettype none
module utms_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_last,
	output logic in_ready,
	input wire utms_pkg::flags_t flags,
	output utms_pkg::cmd_t cmd
);
	import utms_pkg::*;

	localparam logic [4:0] S_LOAD = 5'd0, S_INIT = 5'd1, S_RD0 = 5'd2, S_WB0 = 5'd3,
		S_RD2 = 5'd4, S_WB2 = 5'd5, S_MID = 5'd6, S_RD1 = 5'd7, S_WB1 = 5'd8,
		S_NEXTP = 5'd9, S_PCHK = 5'd10, S_PSTEP = 5'd11, S_PTEST = 5'd12,
		S_PRD = 5'd13, S_PWB = 5'd14, S_PEVAL = 5'd15, S_CHKMID = 5'd16,
		S_LOOP = 5'd17, S_SPLIT = 5'd18, S_NRD = 5'd19, S_NWB = 5'd20,
		S_DECIDE = 5'd21, S_WCHK = 5'd22, S_WRD = 5'd23, S_WWB = 5'd24,
		S_WEVAL = 5'd25, S_EMIT = 5'd26;

	logic [4:0] state_q, state_d;
	logic [1:0] pid_q, pid_d;

	assign in_ready = (state_q == S_LOAD);

	always_comb begin
		state_d = state_q;
		pid_d = pid_q;
		cmd = CMD_NOP;
		case (state_q)
			S_LOAD: if (in_valid && in_last) state_d = S_INIT;
			S_INIT: begin
				cmd = CMD_INIT;
				state_d = S_RD0;
			end
			S_RD0: begin
				cmd = CMD_RD0;
				state_d = S_WB0;
			end
			S_WB0: begin
				cmd = CMD_WB0;
				state_d = S_RD2;
			end
			S_RD2: begin
				cmd = CMD_RD2;
				state_d = S_WB2;
			end
			S_WB2: begin
				cmd = CMD_WB2;
				state_d = S_MID;
			end
			S_MID: begin
				if (flags.two_pt) begin
					cmd = CMD_FIN_TWO;
					state_d = S_EMIT;
				end else begin
					cmd = CMD_MID;
					state_d = S_RD1;
				end
			end
			S_RD1: begin
				cmd = CMD_RD1;
				state_d = S_WB1;
			end
			S_WB1: begin
				cmd = CMD_WB1;
				pid_d = 2'd0;
				state_d = S_NEXTP;
			end
			S_NEXTP: begin
				if (!flags.f1_zero) begin
					state_d = S_CHKMID;
				end else begin
					case (pid_q)
						2'd0: begin
							cmd = CMD_PSL;
							state_d = S_PCHK;
						end
						2'd1: begin
							if (flags.left_zero) pid_d = 2'd2;
							else begin
								cmd = CMD_PSZ;
								state_d = S_PCHK;
							end
						end
						2'd2: begin
							if (flags.right_max) pid_d = 2'd3;
							else begin
								cmd = CMD_PSR;
								state_d = S_PCHK;
							end
						end
						default: begin
							cmd = CMD_FIN_NONE;
							state_d = S_EMIT;
						end
					endcase
				end
			end
			S_PCHK: begin
				if (flags.step_done) begin
					pid_d = pid_q + 2'd1;
					state_d = S_NEXTP;
				end else begin
					state_d = S_PSTEP;
				end
			end
			S_PSTEP: begin
				cmd = CMD_PSTEP;
				state_d = S_PTEST;
			end
			S_PTEST: begin
				if (flags.probe_out) begin
					pid_d = pid_q + 2'd1;
					state_d = S_NEXTP;
				end else begin
					state_d = S_PRD;
				end
			end
			S_PRD: begin
				cmd = CMD_RDN;
				state_d = S_PWB;
			end
			S_PWB: begin
				cmd = CMD_WBN;
				state_d = S_PEVAL;
			end
			S_PEVAL: begin
				if (flags.fn_pos) begin
					cmd = CMD_PHIT;
					state_d = S_NEXTP;
				end else begin
					state_d = S_PCHK;
				end
			end
			S_CHKMID: begin
				if (flags.f1_below) begin
					cmd = CMD_FIN_NU;
					state_d = S_EMIT;
				end else begin
					state_d = S_LOOP;
				end
			end
			S_LOOP: begin
				if (flags.adjacent) begin
					cmd = CMD_FIN_ADJ;
					state_d = S_EMIT;
				end else begin
					cmd = CMD_MUL;
					state_d = S_SPLIT;
				end
			end
			S_SPLIT: begin
				cmd = CMD_SPLIT;
				state_d = S_NRD;
			end
			S_NRD: begin
				cmd = CMD_RDN;
				state_d = S_NWB;
			end
			S_NWB: begin
				cmd = CMD_WBN;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (flags.fn_below) begin
					cmd = CMD_FIN_NU;
					state_d = S_EMIT;
				end else if (flags.fn_ne_f1 || flags.th_gt || flags.ot_gt) begin
					cmd = CMD_UPD;
					state_d = S_LOOP;
				end else begin
					cmd = CMD_WSTART;
					state_d = S_WCHK;
				end
			end
			S_WCHK: begin
				if (!flags.step_done && flags.walk_in) begin
					cmd = CMD_WSTEP;
					state_d = S_WRD;
				end else begin
					cmd = CMD_FIN_NU;
					state_d = S_EMIT;
				end
			end
			S_WRD: begin
				cmd = CMD_RDN;
				state_d = S_WWB;
			end
			S_WWB: begin
				cmd = CMD_WBN;
				state_d = S_WEVAL;
			end
			S_WEVAL: begin
				if (flags.fn_lt_f1) begin
					cmd = CMD_FIN_MID;
					state_d = S_EMIT;
				end else begin
					state_d = S_WCHK;
				end
			end
			S_EMIT: begin
				if (flags.out_free) begin
					cmd = CMD_EMIT;
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			pid_q <= 2'd0;
		end else begin
			state_q <= state_d;
			pid_q <= pid_d;
		end
	end
endmodule
`default_nettype wire

### src/unimodal_table_mode_search.sv
// Top level: mode search over a loaded discrete probability table.
//
// Input stream: one table entry per transfer on s_tdata (0.32 fixed point);
// s_tlast marks the final entry of a vector. Entries load at one per cycle.
// Entry i belongs to index domain_left + i; domain_left is APB register 0.
// After the final entry, s_tready drops while the search runs. A
// golden-section iteration runs multiply, split, read, write-back and
// decide; a probe step runs check, step, test, read, write-back and
// evaluate; a tie-walk step runs check, read, write-back and evaluate.
// One result transfer follows each vector: m_tdata carries mode_index and
// m_tuser carries status. The result waits in an output register; a stalled
// receiver holds the block only when the next result is ready. Reset clears
// the entry count, the pending result and domain_left; the table needs
// no clearing pass. Entries beyond TABLE_DEPTH are dropped.
`timescale 1ns / 1ps
`default_nettype none
module unimodal_table_mode_search #(
	parameter int TABLE_DEPTH = 1024,
	parameter int MAX_TRIALS = 100
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [31:0] s_tdata, // [31:0] probability
	input wire logic s_tlast, // last_entry
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [31:0] m_tdata, // [31:0] mode_index
	output logic [1:0] m_tuser, // [1:0] status
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import utms_pkg::*;

	localparam logic [2:0] ADDR_DOMAIN_LEFT = 3'd0;

	logic [31:0] domain_left_q;
	cmd_t cmd;
	flags_t flags;
	status_t status;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_DOMAIN_LEFT) ? domain_left_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			domain_left_q <= 32'd0;
		end else if (psel && penable && pwrite && paddr == ADDR_DOMAIN_LEFT) begin
			domain_left_q <= pwdata;
		end
	end

	utms_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_last(s_tlast),
		.in_ready(s_tready),
		.flags(flags),
		.cmd(cmd)
	);

	utms_dp #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_TRIALS(MAX_TRIALS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.load_en(s_tvalid && s_tready),
		.load_data(s_tdata),
		.domain_left(domain_left_q),
		.flags(flags),
		.m_valid(m_tvalid),
		.m_ready(m_tready),
		.mode_index(m_tdata),
		.status(status)
	);

	assign m_tuser = status;
endmodule
`default_nettype wire
